FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion helpers; bodies drop out when SYNTHESIS is defined.
`ifndef SYNTHESIS
`define HDG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HDG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HDG_ASSERT(lbl, clk, rst_n, prop, msg)
`define HDG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: design/hdg_pkg.sv
package hdg_pkg;

    localparam int ROT_W = 20;
    localparam int Z_W   = 34;
    localparam int VEC_W = 56;
    localparam int PH_W  = 32;
    localparam int TAB_LEN = 24;

    localparam logic [ROT_W-1:0] GAIN_Q16     = 20'd39797;
    localparam logic [31:0]      HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0]      QUARTER_TURN = 32'h4000_0000;
    localparam logic [15:0]      FULL_HUND    = 16'd36000;
    localparam logic [31:0]      HALF_HUND    = 32'd18000;
    // 2^32 = PH_BASE * 36000 + PH_REM
    localparam logic [31:0]      PH_BASE      = 32'd119304;
    localparam logic [31:0]      PH_REM       = 32'd23296;
    // ceil(2^35 / 1125), exact floor division for 25-bit dividends
    localparam logic [24:0]      RECIP_1125   = 25'd30541990;

    localparam logic [31:0] ATAN_PHASE [TAB_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [Z_W-1:0]   z;
    } rot_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [PH_W-1:0]         z;
    } vec_t;

endpackage

FILE: design/hdg_phase.sv
module hdg_phase import hdg_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic signed [15:0]  angle,
    output logic [PH_W-1:0]     phase
);

    logic signed [16:0] a_ext;
    logic [16:0]        mag;
    logic [29:0]        n_next;
    logic [31:0]        base_next;
    logic [49:0]        p_next;
    logic [31:0]        r_sum;
    logic [PH_W-1:0]    phase_next;

    logic [29:0]        n_reg;
    logic [31:0]        base_a_reg;
    logic               neg_a_reg;
    logic [49:0]        p_reg;
    logic [31:0]        base_b_reg;
    logic               neg_b_reg;
    logic [PH_W-1:0]    phase_reg;

    always_comb
    begin
        a_ext      = {angle[15], angle};
        mag        = a_ext[16] ? 17'(-a_ext) : 17'(a_ext);
        n_next     = 30'(32'(mag) * PH_REM + HALF_HUND);
        base_next  = 32'(32'(mag) * PH_BASE);
        p_next     = {25'd0, n_reg[29:5]} * {25'd0, RECIP_1125};
        r_sum      = base_b_reg + 32'(p_reg[49:35]);
        phase_next = neg_b_reg ? (32'd0 - r_sum) : r_sum;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg      <= n_next;
            base_a_reg <= base_next;
            neg_a_reg  <= angle[15];
            p_reg      <= p_next;
            base_b_reg <= base_a_reg;
            neg_b_reg  <= neg_a_reg;
            phase_reg  <= phase_next;
        end
    end

    assign phase = phase_reg;

endmodule

FILE: design/hdg_rot_cell.sv
module hdg_rot_cell import hdg_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic clk,
    input  logic en,
    input  rot_t din,
    output rot_t dout
);

    logic signed [ROT_W-1:0] dx;
    logic signed [ROT_W-1:0] dy;
    logic signed [Z_W-1:0]   ang;
    rot_t                    res_next;
    rot_t                    res_reg;

    always_comb
    begin
        dx  = $signed(din.x) >>> STEP;
        dy  = $signed(din.y) >>> STEP;
        ang = $signed({2'b00, ATAN_PHASE[STEP]});
        // rotate toward zero residual angle
        if (!din.z[Z_W-1])
        begin
            res_next.x = din.x - dy;
            res_next.y = din.y + dx;
            res_next.z = din.z - ang;
        end
        else
        begin
            res_next.x = din.x + dy;
            res_next.y = din.y - dx;
            res_next.z = din.z + ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign dout = res_reg;

endmodule

FILE: design/hdg_vec_cell.sv
module hdg_vec_cell import hdg_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic clk,
    input  logic en,
    input  vec_t din,
    output vec_t dout
);

    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    vec_t                    res_next;
    vec_t                    res_reg;

    always_comb
    begin
        dx = $signed(din.y) >>> STEP;
        dy = $signed(din.x) >>> STEP;
        // drive y toward zero, accumulate the angle turned
        if ($signed(din.y) > 0)
        begin
            res_next.x = din.x + dx;
            res_next.y = din.y - dy;
            res_next.z = din.z + ATAN_PHASE[STEP];
        end
        else
        begin
            res_next.x = din.x - dx;
            res_next.y = din.y + dy;
            res_next.z = din.z - ATAN_PHASE[STEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign dout = res_reg;

endmodule

FILE: design/tilt_compensated_compass_heading.sv
// Tilt-compensated compass heading. Each input beat carries three signed
// magnetometer axes and roll/pitch in hundredths of a degree; each output
// beat carries the azimuth in hundredths of a degree (0..35999) with the
// declination register already added and wrapped. The block is a fully
// pipelined chain: three stages turn the tilt angles into binary phases,
// CORDIC_STEPS rotation cells produce sine and cosine, one stage fixes the
// half-turn fold, two multiply stages form the horizontal components,
// CORDIC_STEPS vectoring cells find the angle, and two stages scale and wrap
// it. One beat is accepted every cycle while the output is taken or empty.
// The whole pipe advances together, so a stalled output beat holds every
// stage. Write declination only while the pipe is empty; cfg_ready is
// always high.
module tilt_compensated_compass_heading import hdg_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] mag_x,
    input  logic signed [15:0] mag_y,
    input  logic signed [15:0] mag_z,
    input  logic signed [15:0] roll_angle,
    input  logic signed [15:0] pitch_angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        heading,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic signed [15:0] declination
);

`include "assert_macros.svh"

    localparam int N      = CORDIC_STEPS;
    localparam int MD_LEN = N + 4;
    localparam int TOTAL  = 2 * N + 8;

    logic                    adv;
    logic [TOTAL-1:0]        v_reg;
    logic [TOTAL-1:0]        v_next;
    logic signed [15:0]      decl_reg;

    logic [PH_W-1:0]         roll_ph;
    logic [PH_W-1:0]         pitch_ph;
    logic [31:0]             roll_q;
    logic [31:0]             pitch_q;
    logic [31:0]             roll_f;
    logic [31:0]             pitch_f;
    logic                    roll_flip;
    logic                    pitch_flip;

    rot_t                    roll_s  [N+1];
    rot_t                    pitch_s [N+1];
    vec_t                    vec_s   [N+1];

    logic signed [15:0]      mx_reg [MD_LEN];
    logic signed [15:0]      my_reg [MD_LEN];
    logic signed [15:0]      mz_reg [MD_LEN];
    logic                    flr_reg [N];
    logic                    flp_reg [N];
    logic                    zf_reg  [N];

    logic signed [ROT_W-1:0] sr_reg;
    logic signed [ROT_W-1:0] cr_reg;
    logic signed [ROT_W-1:0] sp_reg;
    logic signed [ROT_W-1:0] cp_reg;

    logic signed [35:0]      a_next;
    logic signed [36:0]      bc_next;
    logic signed [36:0]      de_next;
    logic signed [35:0]      a_reg;
    logic signed [36:0]      bc_reg;
    logic signed [36:0]      de_reg;
    logic signed [ROT_W-1:0] sp_p1_reg;

    logic signed [VEC_W-1:0] xh_next;
    logic signed [VEC_W-1:0] yh_next;
    logic signed [VEC_W-1:0] xh_reg;
    logic signed [VEC_W-1:0] yh_reg;
    logic                    vec_zero;
    logic                    vec_neg;

    logic [31:0]             theta;
    logic [47:0]             prod_next;
    logic [15:0]             hund_reg;
    logic signed [17:0]      sum;
    logic signed [17:0]      sum_wrap;
    logic [15:0]             heading_reg;

    // Advance the whole pipe unless the output beat is stuck.
    assign adv       = !v_reg[TOTAL-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[TOTAL-1];
    assign heading   = heading_reg;
    assign cfg_ready = 1'b1;
    assign v_next    = {v_reg[TOTAL-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            decl_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                v_reg <= v_next;
            end
            if (cfg_valid)
            begin
                decl_reg <= declination;
            end
        end
    end

    // Tilt angles to 32-bit phases.
    hdg_phase u_roll_phase
    (
        .clk   (clk),
        .en    (adv),
        .angle (roll_angle),
        .phase (roll_ph)
    );

    hdg_phase u_pitch_phase
    (
        .clk   (clk),
        .en    (adv),
        .angle (pitch_angle),
        .phase (pitch_ph)
    );

    // Fold angles in the back half-plane by a half turn; undo at the end.
    always_comb
    begin
        roll_q     = roll_ph + QUARTER_TURN;
        pitch_q    = pitch_ph + QUARTER_TURN;
        roll_flip  = roll_q[31];
        pitch_flip = pitch_q[31];
        roll_f     = roll_flip ? (roll_ph + HALF_TURN) : roll_ph;
        pitch_f    = pitch_flip ? (pitch_ph + HALF_TURN) : pitch_ph;

        roll_s[0].x  = $signed(GAIN_Q16);
        roll_s[0].y  = '0;
        roll_s[0].z  = $signed({{2{roll_f[31]}}, roll_f});
        pitch_s[0].x = $signed(GAIN_Q16);
        pitch_s[0].y = '0;
        pitch_s[0].z = $signed({{2{pitch_f[31]}}, pitch_f});
    end

    // Rotation cells, one per CORDIC step, both tilt angles side by side.
    for (genvar k = 0; k < N; k++)
    begin : g_rot
        hdg_rot_cell #(.STEP(k)) u_roll_cell
        (
            .clk  (clk),
            .en   (adv),
            .din  (roll_s[k]),
            .dout (roll_s[k+1])
        );

        hdg_rot_cell #(.STEP(k)) u_pitch_cell
        (
            .clk  (clk),
            .en   (adv),
            .din  (pitch_s[k]),
            .dout (pitch_s[k+1])
        );
    end

    // Horizontal components: XH = mx*cp<<16 + (my*sr - mz*cr)*sp,
    // YH = (my*cr + mz*sr)<<16.
    always_comb
    begin
        a_next  = 36'(mx_reg[N+3]) * 36'(cp_reg);
        bc_next = 37'(my_reg[N+3]) * 37'(sr_reg) - 37'(mz_reg[N+3]) * 37'(cr_reg);
        de_next = 37'(my_reg[N+3]) * 37'(cr_reg) + 37'(mz_reg[N+3]) * 37'(sr_reg);
        xh_next = (VEC_W'(a_reg) <<< 16) + VEC_W'(bc_reg) * VEC_W'(sp_p1_reg);
        yh_next = VEC_W'(de_reg) <<< 16;

        vec_zero   = (xh_reg == '0) && (yh_reg == '0);
        vec_neg    = xh_reg[VEC_W-1];
        vec_s[0].x = vec_neg ? -xh_reg : xh_reg;
        vec_s[0].y = vec_neg ? -yh_reg : yh_reg;
        vec_s[0].z = vec_neg ? HALF_TURN : 32'd0;
    end

    // Vectoring cells for atan2.
    for (genvar k = 0; k < N; k++)
    begin : g_vec
        hdg_vec_cell #(.STEP(k)) u_vec_cell
        (
            .clk  (clk),
            .en   (adv),
            .din  (vec_s[k]),
            .dout (vec_s[k+1])
        );
    end

    // Phase to hundredths, then add declination and wrap once.
    always_comb
    begin
        theta     = zf_reg[N-1] ? 32'd0 : vec_s[N].z;
        prod_next = {16'd0, theta} * {32'd0, FULL_HUND} + {16'd0, HALF_TURN};
        sum       = $signed({2'b00, hund_reg}) + 18'(decl_reg);
        if (sum < 0)
        begin
            sum_wrap = sum + $signed({2'b00, FULL_HUND});
        end
        else if (sum >= $signed({2'b00, FULL_HUND}))
        begin
            sum_wrap = sum - $signed({2'b00, FULL_HUND});
        end
        else
        begin
            sum_wrap = sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx_reg[0]  <= mag_x;
            my_reg[0]  <= mag_y;
            mz_reg[0]  <= mag_z;
            for (int i = 1; i < MD_LEN; i++)
            begin
                mx_reg[i] <= mx_reg[i-1];
                my_reg[i] <= my_reg[i-1];
                mz_reg[i] <= mz_reg[i-1];
            end
            flr_reg[0] <= roll_flip;
            flp_reg[0] <= pitch_flip;
            zf_reg[0]  <= vec_zero;
            for (int i = 1; i < N; i++)
            begin
                flr_reg[i] <= flr_reg[i-1];
                flp_reg[i] <= flp_reg[i-1];
                zf_reg[i]  <= zf_reg[i-1];
            end

            sr_reg <= flr_reg[N-1] ? -roll_s[N].y  : roll_s[N].y;
            cr_reg <= flr_reg[N-1] ? -roll_s[N].x  : roll_s[N].x;
            sp_reg <= flp_reg[N-1] ? -pitch_s[N].y : pitch_s[N].y;
            cp_reg <= flp_reg[N-1] ? -pitch_s[N].x : pitch_s[N].x;

            a_reg     <= a_next;
            bc_reg    <= bc_next;
            de_reg    <= de_next;
            sp_p1_reg <= sp_reg;

            xh_reg <= xh_next;
            yh_reg <= yh_next;

            hund_reg    <= prod_next[47:32];
            heading_reg <= 16'(sum_wrap);
        end
    end

    `HDG_ASSERT_ALWAYS(a_heading_range, clk, out_valid |-> (heading < FULL_HUND), "heading out of range")
    `HDG_ASSERT(a_cfg_write, clk, rst_n, cfg_valid |=> (decl_reg == $past(declination)), "declination not taken")
    `HDG_ASSERT(a_pipe_drain, clk, rst_n, (v_reg[TOTAL-2] && adv) |=> out_valid, "beat lost before output")

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import hdg_pkg::*;

    localparam int STEPS    = 16;
    localparam int LATENCY  = 2 * STEPS + 8;
    localparam int N_RANDOM = 960;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] mag_x = '0;
    logic signed [15:0] mag_y = '0;
    logic signed [15:0] mag_z = '0;
    logic signed [15:0] roll_angle = '0;
    logic signed [15:0] pitch_angle = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [15:0]        heading;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic signed [15:0] decl_data = '0;

    // Predictor copy of the declination register and the pending headings.
    logic signed [15:0] decl_now = '0;
    logic [15:0]        heading_q[$];
    int                 n_errors = 0;
    int                 n_checked = 0;
    int                 n_sent = 0;
    int                 n_decl = 0;

    // Receiver controls: steady mode disables random stalls; hold request
    // makes the receiver refuse results for a long count of cycles.
    bit                 steady = 1'b0;
    bit                 long_hold_req = 1'b0;
    int                 hold_cnt = 0;

    tilt_compensated_compass_heading #(.CORDIC_STEPS(STEPS)) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mag_x       (mag_x),
        .mag_y       (mag_y),
        .mag_z       (mag_z),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .heading     (heading),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .declination (decl_data)
    );

    always #4 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("timeout at %0t", $time);
        $display("FAILURE");
        $finish;
    end

    // Convert hundredths of a degree to a 32-bit binary phase, rounding
    // the magnitude half away from zero before applying the sign.
    function automatic logic [31:0] hund_phase(input logic signed [15:0] a);
        longint unsigned mag;
        longint unsigned p;
        logic [31:0]     r;
        mag = (a < 0) ? longint'(-int'(a)) : longint'(a);
        p = ((mag << 32) + 64'd18000) / 64'd36000;
        r = p[31:0];
        if (a < 0)
            r = -r;
        return r;
    endfunction

    // Rotation CORDIC; fold angles in [90, 270) by a half turn and negate.
    function automatic void sine_cosine(input logic [31:0] ph,
                                        output longint s, output longint c);
        bit     flip;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        logic [31:0] t;
        t = ph + QUARTER_TURN;
        flip = t[31];
        if (flip)
            ph = ph + HALF_TURN;
        x = 39797;
        y = 0;
        z = longint'($signed(ph));
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_PHASE[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_PHASE[i]);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    // Vectoring CORDIC: phase of (x, y); zero vector gives phase zero.
    function automatic logic [31:0] vector_angle(input longint x, input longint y);
        logic [31:0] z;
        longint      dx;
        longint      dy;
        z = '0;
        if (x == 0 && y == 0)
            return '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_PHASE[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_PHASE[i];
            end
        end
        return z;
    endfunction

    function automatic logic [15:0] compass_heading(
        input logic signed [15:0] mx, input logic signed [15:0] my,
        input logic signed [15:0] mz, input logic signed [15:0] roll,
        input logic signed [15:0] pitch, input logic signed [15:0] decl);
        longint sr, cr, sp, cp, xh, yh, hund, total;
        longint unsigned theta;
        sine_cosine(hund_phase(roll), sr, cr);
        sine_cosine(hund_phase(pitch), sp, cp);
        xh = longint'(mx) * cp * 65536 + longint'(my) * sr * sp
           - longint'(mz) * cr * sp;
        yh = (longint'(my) * cr + longint'(mz) * sr) * 65536;
        theta = vector_angle(xh, yh);
        hund = longint'((theta * 64'd36000 + 64'h8000_0000) >> 32);
        // Wrap the declination-corrected heading once into a full circle.
        total = hund + longint'(decl);
        if (total < 0)
            total = total + 36000;
        else if (total >= 36000)
            total = total - 36000;
        return total[15:0];
    endfunction

    // Observe every handshake half a cycle ahead of the edge that takes it;
    // the values are stable here, so nothing depends on event order.
    always @(negedge clk)
    begin
        logic [15:0] want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (heading_q.size() == 0)
                begin
                    $display("%0t: unexpected heading beat, actual %0d", $time, heading);
                    n_errors++;
                end
                else
                begin
                    want = heading_q.pop_front();
                    n_checked++;
                    if (heading !== want)
                    begin
                        $display("%0t: heading mismatch, expected %0d actual %0d",
                                 $time, want, heading);
                        n_errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                heading_q.push_back(compass_heading(mag_x, mag_y, mag_z,
                                                    roll_angle, pitch_angle, decl_now));
                n_sent++;
            end
            if (cfg_valid && cfg_ready)
            begin
                decl_now = decl_data;
                n_decl++;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, a long hold on request, none in steady mode.
    always @(posedge clk)
    begin
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_cnt = 4 * LATENCY;
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else if (steady)
            out_ready <= 1'b1;
        else
            out_ready <= (pick_gap() == 0) || ($urandom_range(0, 3) != 0);
    end

    // Offer one beat, hold it until taken, then optionally drop valid.
    task automatic send_sample(input logic signed [15:0] mx, input logic signed [15:0] my,
                               input logic signed [15:0] mz, input logic signed [15:0] roll,
                               input logic signed [15:0] pitch, input bit gaps);
        int gap;
        mag_x       <= mx;
        mag_y       <= my;
        mag_z       <= mz;
        roll_angle  <= roll;
        pitch_angle <= pitch;
        in_valid    <= 1'b1;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        gap = gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (heading_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // Write the declination only with the pipe empty.
    task automatic set_declination(input logic signed [15:0] v);
        drain_pipe();
        decl_data <= v;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_angle();
        if ($urandom_range(0, 15) == 0)
            return 16'($urandom());
        return $signed(16'($urandom_range(0, 36000))) - 16'sd18000;
    endfunction

    function automatic logic signed [15:0] rand_axis();
        if ($urandom_range(0, 7) == 0)
            return $signed(16'($urandom_range(0, 200))) - 16'sd100;
        return 16'($urandom());
    endfunction

    // Axis extremes, tilt extremes, zero vector, angles past a half turn.
    task automatic test_directed();
        set_declination(16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1);
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd18000, -16'sd18000, 1);
        send_sample(16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1);
        send_sample(-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1);
        send_sample(16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1);
        send_sample(16'sd0, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 1);
        send_sample(16'sd0, 16'sd0, -16'sd32768, 16'sd9000, 16'sd0, 1);
        send_sample(16'sd0, 16'sd0, 16'sd32767, -16'sd9000, 16'sd9000, 1);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd18000, -16'sd18000, 0);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767, 16'sd18000, 16'sd18000, 0);
        send_sample(16'sd1000, -16'sd1, 16'sd500, 16'sd32767, -16'sd32768, 1);
        send_sample(16'sd1000, 16'sd1, -16'sd500, -16'sd32768, 16'sd32767, 1);
        send_sample(-16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1);
        send_sample(-16'sd1000, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 1);
        set_declination(16'sd18000);
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1);
        send_sample(-16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1);
        set_declination(-16'sd18000);
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1);
        send_sample(16'sd1000, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 1);
        // Out-of-range declinations still add as signed values.
        set_declination(16'sd32767);
        send_sample(16'sd3000, 16'sd3000, 16'sd0, 16'sd0, 16'sd0, 1);
        set_declination(-16'sd32768);
        send_sample(16'sd3000, -16'sd3000, 16'sd0, 16'sd0, 16'sd0, 1);
    endtask

    // Random samples in phases, each with its own declination.
    task automatic test_random();
        logic signed [15:0] d;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: d = 16'sd0;
                1: d = 16'sd18000;
                2: d = -16'sd18000;
                3: d = 16'($urandom());
                default: d = $signed(16'($urandom_range(0, 36000))) - 16'sd18000;
            endcase
            set_declination(d);
            steady = (ph == 2);
            for (int k = 0; k < N_RANDOM / 5; k++)
                send_sample(rand_axis(), rand_axis(), rand_axis(),
                            rand_angle(), rand_angle(), !steady);
        end
        steady = 1'b0;
    endtask

    // Hold the receiver off while beats keep coming, to fill the pipe.
    task automatic test_backpressure();
        set_declination(16'sd1234);
        long_hold_req = 1'b1;
        for (int k = 0; k < 3 * LATENCY; k++)
            send_sample(rand_axis(), rand_axis(), rand_axis(),
                        rand_angle(), rand_angle(), 0);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_backpressure();
        drain_pipe();
        $display("sent %0d samples, checked %0d headings, %0d declination writes",
                 n_sent, n_checked, n_decl);
        $display("covered axis and tilt extremes, zero vector, wrap, and a full-pipe stall");
        if (n_errors == 0 && heading_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
